@@ src/anp_pkg.sv @@
// shared types and character constants for the ascii number parser
package anp_pkg;

    // radix selection held in the configuration register
    typedef enum logic [1:0] {
        MODE_OCT = 2'd0,
        MODE_DEC = 2'd1,
        MODE_HEX = 2'd2
    } radix_mode_t;

    // where the parser stands within the current numeral
    typedef enum logic [1:0] {
        POS_FIRST      = 2'd0,
        POS_AFTER_ZERO = 2'd1,
        POS_LATER      = 2'd2
    } char_pos_t;

    localparam int ValueWidth = 64;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LX    = 8'h78;

    // one character request as held in the input register
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_req_t;

    // finished numeral handed to the result register
    typedef struct packed {
        logic                  load;
        logic [ValueWidth-1:0] value;
        logic                  ok;
    } res_ctl_t;

endpackage

@@ src/anp_in_stage.sv @@
// input register for character requests
module anp_in_stage import anp_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  logic [7:0] char_in,
    input  logic      last_char,
    input  logic      take,
    output logic      s1_valid,
    output char_req_t s1_req
);

    logic      valid_reg;
    logic      valid_next;
    char_req_t req_reg;
    logic      accept;

    // hold off the sender only while the held request cannot move on
    assign in_stall = valid_reg && !take;
    assign accept   = in_valid && !in_stall;

    // occupancy of the input register
    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // request payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.ch   <= char_in;
            req_reg.last <= last_char;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_req   = req_reg;

endmodule

@@ src/anp_parse_core.sv @@
// radix register, numeral state and the per-character check and accumulate step
module anp_parse_core import anp_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,
    input  logic       s1_valid,
    input  char_req_t  s1_req,
    input  logic       out_free,
    output logic       take,
    output res_ctl_t   res
);

    radix_mode_t           mode_reg;
    logic [ValueWidth-1:0] acc_reg;
    logic [ValueWidth-1:0] acc_next;
    logic                  bad_reg;
    logic                  bad_next;
    char_pos_t             pos_reg;
    char_pos_t             pos_next;

    logic [ValueWidth-1:0] acc_step;
    logic                  bad_step;
    char_pos_t             pos_step;
    logic [ValueWidth-1:0] dig64;
    logic [3:0]            hex_val;
    logic                  hex_ok;
    logic                  dec_ok;
    logic                  oct_ok;
    logic                  is_x;
    logic [7:0]            c;

    assign c = s1_req.ch;

    // radix configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_DEC;
        end
        else if (cfg_wr_en)
        begin
            mode_reg <= radix_mode_t'(cfg_wr_data);
        end
    end

    // character classes and digit value
    always_comb
    begin
        oct_ok  = (c >= CH_ZERO) && (c <= CH_SEVEN);
        dec_ok  = (c >= CH_ZERO) && (c <= CH_NINE);
        is_x    = (c == CH_LX) || (c == CH_UX);
        hex_ok  = 1'b0;
        hex_val = 4'd0;
        if (dec_ok)
        begin
            hex_ok  = 1'b1;
            hex_val = c[3:0];
        end
        else if (((c >= CH_LA) && (c <= CH_LF)) || ((c >= CH_UA) && (c <= CH_UF)))
        begin
            hex_ok  = 1'b1;
            hex_val = c[3:0] + 4'd9;
        end
        dig64 = {{(ValueWidth-4){1'b0}}, hex_val};
    end

    // one step of check and multiply-add under the current radix
    always_comb
    begin
        acc_step = acc_reg;
        bad_step = bad_reg;
        case (mode_reg)
            MODE_OCT:
            begin
                if ((pos_reg == POS_FIRST) && (c != CH_ZERO))
                begin
                    bad_step = 1'b1;
                end
                else if (oct_ok)
                begin
                    acc_step = {acc_reg[ValueWidth-4:0], 3'b000} + dig64;
                end
                else
                begin
                    bad_step = 1'b1;
                end
            end
            MODE_DEC:
            begin
                if (dec_ok)
                begin
                    acc_step = {acc_reg[ValueWidth-4:0], 3'b000}
                             + {acc_reg[ValueWidth-2:0], 1'b0} + dig64;
                end
                else
                begin
                    bad_step = 1'b1;
                end
            end
            MODE_HEX:
            begin
                if ((pos_reg == POS_AFTER_ZERO) && is_x)
                begin
                    acc_step = acc_reg;
                end
                else if (hex_ok)
                begin
                    acc_step = {acc_reg[ValueWidth-5:0], 4'b0000} + dig64;
                end
                else
                begin
                    bad_step = 1'b1;
                end
            end
            default:
            begin
                bad_step = 1'b1;
            end
        endcase

        case (pos_reg)
            POS_FIRST: pos_step = (c == CH_ZERO) ? POS_AFTER_ZERO : POS_LATER;
            default:   pos_step = POS_LATER;
        endcase
    end

    // a last character needs a free result slot, others move on at once
    assign take = s1_valid && (!s1_req.last || out_free);

    assign res.load  = take && s1_req.last;
    assign res.value = bad_step ? '0 : acc_step;
    assign res.ok    = !bad_step;

    // numeral state, cleared after the last character
    always_comb
    begin
        acc_next = acc_reg;
        bad_next = bad_reg;
        pos_next = pos_reg;
        if (take)
        begin
            if (s1_req.last)
            begin
                acc_next = '0;
                bad_next = 1'b0;
                pos_next = POS_FIRST;
            end
            else
            begin
                acc_next = acc_step;
                bad_next = bad_step;
                pos_next = pos_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            bad_reg <= 1'b0;
            pos_reg <= POS_FIRST;
        end
        else
        begin
            acc_reg <= acc_next;
            bad_reg <= bad_next;
            pos_reg <= pos_next;
        end
    end

endmodule

@@ src/anp_out_stage.sv @@
// result register feeding the output channel
module anp_out_stage import anp_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  res_ctl_t              res,
    output logic                  out_free,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [ValueWidth-1:0] number_value,
    output logic                  number_ok
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [ValueWidth-1:0] value_reg;
    logic                  ok_reg;

    // slot is free when empty or being taken this cycle
    assign out_free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (res.load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            value_reg <= res.value;
            ok_reg    <= res.ok;
        end
    end

    assign out_valid    = valid_reg;
    assign number_value = value_reg;
    assign number_ok    = ok_reg;

endmodule

@@ src/ascii_number_parser_top.sv @@
// top level of the ascii octal, decimal and hex numeral parser
// throughput: one character request per cycle, set by the multiply-add feedback
//   on the 64-bit accumulator; a last character waits while the result is full and stalled
// path: an accepted last character is held in the input register and its result is loaded
//   into the result register once the result slot is free
// reset: asynchronous active low; clears numeral state, empties both registers and
//   sets the radix to decimal
module ascii_number_parser_top import anp_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            char_in,
    input  logic                  last_char,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [ValueWidth-1:0] number_value,
    output logic                  number_ok
);

    logic      s1_valid;
    char_req_t s1_req;
    logic      take;
    logic      out_free;
    res_ctl_t  res;

    // character request register
    anp_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_in   (char_in),
        .last_char (last_char),
        .take      (take),
        .s1_valid  (s1_valid),
        .s1_req    (s1_req)
    );

    // check and accumulate
    anp_parse_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s1_valid    (s1_valid),
        .s1_req      (s1_req),
        .out_free    (out_free),
        .take        (take),
        .res         (res)
    );

    // result register
    anp_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .res          (res),
        .out_free     (out_free),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .number_value (number_value),
        .number_ok    (number_ok)
    );

endmodule

@@ src/anp_checker.sv @@
// port-level checks for the ascii number parser
module anp_checker import anp_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [ValueWidth-1:0] number_value,
    input logic                  number_ok
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(number_value) && $stable(number_ok))
        else $error("stalled result changed");

    // a rejected numeral reports value zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !number_ok |-> number_value == '0)
        else $error("invalid numeral with nonzero value");

    // input backpressure only when the result slot is full and stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || !out_stall) |-> !in_stall)
        else $error("input stalled while result slot free");

    // a result never appears without a request having been taken before
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid, 2) || $past(in_stall))
        else $error("result without request");

endmodule

bind ascii_number_parser_top anp_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .number_value (number_value),
    .number_ok    (number_ok)
);
